// File: src/quoted_literal_scanner_core_defines.svh
// Assertion macros for the quoted literal scanner.
// Used by the top level; expects clk and arst_n in scope.
`ifndef QUOTED_LITERAL_SCANNER_CORE_DEFINES_SVH
`define QUOTED_LITERAL_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QLS_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define QLS_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: src/qls_pkg.sv
// Shared types, byte codes and escape decoder for the quoted literal scanner.
// No dependencies.
`timescale 1ns / 1ps

package qls_pkg;

	localparam int OUT_W = 16;

	typedef logic [OUT_W-1:0] out_cnt_t;

	localparam logic [1:0] KIND_INVALID = 2'd0;
	localparam logic [1:0] KIND_CHAR    = 2'd1;
	localparam logic [1:0] KIND_STRING  = 2'd2;

	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;

	typedef struct packed {
		logic [1:0] kind;
		logic       took_byte;
		out_cnt_t   span_bytes;
		out_cnt_t   char_count;
		out_cnt_t   bad_escapes;
		logic       unterminated;
		logic       bad_char_length;
	} qls_result_t;

	function automatic logic legal_escape(input logic [7:0] c);
		logic ok;
		unique case (c) inside
			CH_APOS, CH_QUOTE, CH_QMARK, CH_BSL,
			CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// File: src/qls_scan.sv
// Token state and per-byte step logic: decides the next state and whether
// this byte closes a token. Depends on qls_pkg.
`timescale 1ns / 1ps

module qls_scan #(
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_cur,
	input  logic                 last,
	output logic                 emit,
	output qls_pkg::qls_result_t res
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_ESC  = 2'd2
	} phase_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	phase_t                phase_q, phase_n;
	logic                  apos_q, apos_n;
	logic [COUNT_BITS-1:0] span_q, span_n;
	logic [COUNT_BITS-1:0] body_q, body_n;
	logic [COUNT_BITS-1:0] esc_q, esc_n;
	logic                  took, closed, invalid;
	qls_pkg::out_cnt_t     span_o, body_o, esc_o;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	wire line_break = (byte_cur == qls_pkg::CH_LF) || (byte_cur == qls_pkg::CH_CR);
	wire [7:0] delim = apos_q ? qls_pkg::CH_APOS : qls_pkg::CH_QUOTE;

	always_comb begin
		phase_n = phase_q;
		apos_n  = apos_q;
		span_n  = span_q;
		body_n  = body_q;
		esc_n   = esc_q;
		emit    = 1'b0;
		took    = 1'b0;
		closed  = 1'b0;
		invalid = 1'b0;
		unique case (phase_q)
			PH_BODY: begin
				if (byte_cur == delim) begin
					span_n  = sat_inc(span_q);
					emit    = 1'b1;
					took    = 1'b1;
					closed  = 1'b1;
					phase_n = PH_IDLE;
				end else if (line_break) begin
					emit    = 1'b1;
					phase_n = PH_IDLE;
				end else begin
					span_n = sat_inc(span_q);
					if (byte_cur == qls_pkg::CH_BSL) begin
						phase_n = PH_ESC;
					end else begin
						body_n = sat_inc(body_q);
					end
					if (last) begin
						emit    = 1'b1;
						took    = 1'b1;
						phase_n = PH_IDLE;
					end
				end
			end
			PH_ESC: begin
				if (line_break) begin
					emit    = 1'b1;
					phase_n = PH_IDLE;
				end else begin
					span_n = sat_inc(span_q);
					body_n = sat_inc(body_q);
					if (!qls_pkg::legal_escape(byte_cur)) begin
						esc_n = sat_inc(esc_q);
					end
					phase_n = last ? PH_IDLE : PH_BODY;
					emit    = last;
					took    = last;
				end
			end
			default: begin
				// idle, and the unused code behaves the same
				if (byte_cur == qls_pkg::CH_APOS || byte_cur == qls_pkg::CH_QUOTE) begin
					apos_n  = (byte_cur == qls_pkg::CH_APOS);
					span_n  = CNT_ONE;
					body_n  = '0;
					esc_n   = '0;
					phase_n = last ? PH_IDLE : PH_BODY;
					emit    = last;
					took    = last;
				end else begin
					emit    = 1'b1;
					invalid = 1'b1;
					phase_n = PH_IDLE;
				end
			end
		endcase
	end

	generate
		if (COUNT_BITS > qls_pkg::OUT_W) begin : g_clamp
			assign span_o = (|span_n[COUNT_BITS-1:qls_pkg::OUT_W]) ? '1
			                                                     : span_n[qls_pkg::OUT_W-1:0];
			assign body_o = (|body_n[COUNT_BITS-1:qls_pkg::OUT_W]) ? '1
			                                                     : body_n[qls_pkg::OUT_W-1:0];
			assign esc_o  = (|esc_n[COUNT_BITS-1:qls_pkg::OUT_W]) ? '1
			                                                    : esc_n[qls_pkg::OUT_W-1:0];
		end else if (COUNT_BITS == qls_pkg::OUT_W) begin : g_same
			assign span_o = span_n;
			assign body_o = body_n;
			assign esc_o  = esc_n;
		end else begin : g_extend
			assign span_o = {{(qls_pkg::OUT_W-COUNT_BITS){1'b0}}, span_n};
			assign body_o = {{(qls_pkg::OUT_W-COUNT_BITS){1'b0}}, body_n};
			assign esc_o  = {{(qls_pkg::OUT_W-COUNT_BITS){1'b0}}, esc_n};
		end
	endgenerate

	always_comb begin
		res = '0;
		if (!invalid) begin
			res.kind            = apos_n ? qls_pkg::KIND_CHAR : qls_pkg::KIND_STRING;
			res.took_byte       = took;
			res.span_bytes      = span_o;
			res.char_count      = body_o;
			res.bad_escapes     = esc_o;
			res.unterminated    = !closed;
			res.bad_char_length = apos_n && (body_n != CNT_ONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			apos_q  <= 1'b0;
			span_q  <= '0;
			body_q  <= '0;
			esc_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			apos_q  <= apos_n;
			span_q  <= span_n;
			body_q  <= body_n;
			esc_q   <= esc_n;
		end
	end

endmodule

// File: src/qls_out_reg.sv
// Result register: holds one finished result until the consumer takes it.
// Depends on qls_pkg.
`timescale 1ns / 1ps

module qls_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  qls_pkg::qls_result_t res_in,
	input  logic                 out_ready,
	output logic                 slot_free,
	output logic                 out_valid,
	output qls_pkg::qls_result_t res_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// File: src/quoted_literal_scanner_core.sv
// Quoted literal scanner: one byte per item, one result per token end or invalid byte.
// The byte that ends a result is held in stage 1, then its result in the result register.
// Throughput: 1 byte per cycle, except while a byte that produces a result stalls.
// A byte that produces a result stalls only while the result register is full and out_ready is low.
// Reset (arst_n low, asynchronous) empties both registers and returns to idle.
`timescale 1ns / 1ps
`include "quoted_literal_scanner_core_defines.svh"

module quoted_literal_scanner_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic        took_byte,
	output logic [15:0] span_bytes,
	output logic [15:0] char_count,
	output logic [15:0] bad_escapes,
	output logic        unterminated,
	output logic        bad_char_length
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 final_s1;
	logic                 emit, slot_free, advance;
	qls_pkg::qls_result_t step_res, res_q;

	// item in stage 1 moves on unless its result has nowhere to go
	assign advance  = valid_s1 && (!emit || slot_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= byte_in;
			final_s1 <= final_byte;
		end
	end

	qls_scan #(
		.COUNT_BITS(COUNT_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.byte_cur (byte_s1),
		.last     (final_s1),
		.emit     (emit),
		.res      (step_res)
	);

	qls_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.res_in    (step_res),
		.out_ready (out_ready),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign kind            = res_q.kind;
	assign took_byte       = res_q.took_byte;
	assign span_bytes      = res_q.span_bytes;
	assign char_count      = res_q.char_count;
	assign bad_escapes     = res_q.bad_escapes;
	assign unterminated    = res_q.unterminated;
	assign bad_char_length = res_q.bad_char_length;

	`QLS_ASSERT_NOW(a_invalid_empty, out_valid && kind == qls_pkg::KIND_INVALID,
		!took_byte && span_bytes == 16'd0 && !unterminated, "invalid start carries data")
	`QLS_ASSERT_NOW(a_token_span, out_valid && kind != qls_pkg::KIND_INVALID,
		span_bytes != 16'd0, "token result with empty span")
	`QLS_ASSERT_NOW(a_badlen_char, out_valid && bad_char_length,
		kind == qls_pkg::KIND_CHAR, "length flag on non-character token")
	`QLS_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance,
		valid_s1 && $stable(byte_s1), "stalled stage 1 item lost")

endmodule
